[design/triangle_box_overlap_macros.svh]
// Assertion macros shared by the triangle/box overlap design.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef TRIANGLE_BOX_OVERLAP_MACROS_SVH
`define TRIANGLE_BOX_OVERLAP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TBO_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("tbo check failed in same cycle");

// The consequent must hold in the cycle after the antecedent.
`define TBO_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tbo check failed in next cycle");

`endif

[design/tbo_pkg.sv]
// Package for the triangle/box overlap pipeline: widths, types and codes.
// Used by every module of the design; depends on nothing.
package tbo_pkg;

  localparam int COORD_WIDTH = 24;
  localparam int HW  = 23;
  localparam int VW  = COORD_WIDTH + 1;
  localparam int EW  = COORD_WIDTH + 2;
  localparam int PW  = EW + VW;
  localparam int DW  = PW + 1;
  localparam int RW  = EW + HW + 1;
  localparam int KW  = ((DW > RW) ? DW : RW) + 1;
  localparam int NW  = 2 * EW + 1;
  localparam int NLO = NW / 2;
  localparam int NHI = NW - NLO;
  localparam int CNW = (((HW + 1) > VW) ? (HW + 1) : VW) + 1;
  localparam int TW  = NW + CNW;
  localparam int SW  = TW + 2;
  localparam int BW  = ((VW > (HW + 1)) ? VW : (HW + 1)) + 1;
  localparam int LATENCY = 7;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [VW-1:0] vcoord_t;
  typedef logic signed [EW-1:0] ecoord_t;
  typedef logic [HW-1:0] half_t;

  typedef enum logic [1:0] {
    CFG_HALF_X = 2'd0,
    CFG_HALF_Y = 2'd1,
    CFG_HALF_Z = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic edge_sep;
    logic box_sep;
  } sep_t;

endpackage

[design/tbo_diff.sv]
// Front stages: vertices moved to the box center, then the edges between the vertices.
// Depends on tbo_pkg.
module tbo_diff (
  input  logic            clk_i,
  input  tbo_pkg::coord_t vert_i [3][3],
  input  tbo_pkg::coord_t center_i [3],
  input  tbo_pkg::half_t  half_i [3],
  output tbo_pkg::vcoord_t v_o [3][3],
  output tbo_pkg::ecoord_t e_o [3][3],
  output tbo_pkg::half_t  half_o [3]
);
  import tbo_pkg::*;

  vcoord_t v1_q [3][3];
  half_t   h1_q [3];
  vcoord_t v2_q [3][3];
  ecoord_t e2_q [3][3];
  half_t   h2_q [3];

  always_ff @(posedge clk_i) begin
    for (int n = 0; n < 3; n++) begin
      for (int k = 0; k < 3; k++) begin
        v1_q[n][k] <= VW'(vert_i[n][k]) - VW'(center_i[k]);
      end
    end
    h1_q <= half_i;
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      e2_q[0][k] <= EW'(v1_q[1][k]) - EW'(v1_q[0][k]);
      e2_q[1][k] <= EW'(v1_q[2][k]) - EW'(v1_q[1][k]);
      e2_q[2][k] <= EW'(v1_q[0][k]) - EW'(v1_q[2][k]);
    end
    v2_q <= v1_q;
    h2_q <= h1_q;
  end

  assign v_o    = v2_q;
  assign e_o    = e2_q;
  assign half_o = h2_q;

endmodule

[design/tbo_edge.sv]
// Edge-cross-axis tests for each edge and box axis, plus the box-axis tests.
// Depends on tbo_pkg.
module tbo_edge (
  input  logic             clk_i,
  input  tbo_pkg::vcoord_t v_i [3][3],
  input  tbo_pkg::ecoord_t e_i [3][3],
  input  tbo_pkg::half_t   half_i [3],
  output tbo_pkg::sep_t    sep_o
);
  import tbo_pkg::*;

  logic signed [PW-1:0] pa_q [3][3][3];
  logic signed [PW-1:0] pb_q [3][3][3];
  logic [EW+HW-1:0]     ra_q [3][3];
  logic [EW+HW-1:0]     rb_q [3][3];
  logic signed [DW-1:0] p_q [3][3][3];
  logic [RW-1:0]        rad_q [3][3];
  logic                 box3_q, box4_q, box5_q, box6_q;
  logic                 edge5_q, edge6_q;
  sep_t                 sep_q;
  logic [EW-1:0]        mag [3][3];
  logic                 box_d;
  logic [8:0]           axis_sep;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      for (int c = 0; c < 3; c++) begin
        mag[k][c] = e_i[k][c][EW-1] ? EW'(-e_i[k][c]) : EW'(e_i[k][c]);
      end
    end
  end

  // Stage three: all products of the edge tests.
  for (genvar k = 0; k < 3; k++) begin : g_edge
    for (genvar a = 0; a < 3; a++) begin : g_axis
      localparam int I = (a == 0) ? 1 : 0;
      localparam int J = (a == 2) ? 1 : 2;
      always_ff @(posedge clk_i) begin
        for (int n = 0; n < 3; n++) begin
          pa_q[k][a][n] <= PW'(e_i[k][J]) * PW'(v_i[n][I]);
          pb_q[k][a][n] <= PW'(e_i[k][I]) * PW'(v_i[n][J]);
        end
        ra_q[k][a] <= (EW+HW)'(mag[k][J]) * (EW+HW)'(half_i[I]);
        rb_q[k][a] <= (EW+HW)'(mag[k][I]) * (EW+HW)'(half_i[J]);
      end
    end
  end

  // The box axis separates when all three vertices lie beyond one face.
  always_comb begin
    logic signed [BW-1:0] hs;
    logic all_hi, all_lo;
    box_d = 1'b0;
    for (int k = 0; k < 3; k++) begin
      hs = BW'($signed({1'b0, half_i[k]}));
      all_hi = 1'b1;
      all_lo = 1'b1;
      for (int n = 0; n < 3; n++) begin
        all_hi &= (BW'(v_i[n][k]) > hs);
        all_lo &= (BW'(v_i[n][k]) < -hs);
      end
      box_d |= all_hi | all_lo;
    end
  end

  always_ff @(posedge clk_i) begin
    box3_q <= box_d;
    for (int k = 0; k < 3; k++) begin
      for (int a = 0; a < 3; a++) begin
        for (int n = 0; n < 3; n++) begin
          p_q[k][a][n] <= DW'(pa_q[k][a][n]) - DW'(pb_q[k][a][n]);
        end
        rad_q[k][a] <= RW'(ra_q[k][a]) + RW'(rb_q[k][a]);
      end
    end
    box4_q <= box3_q;
  end

  // The interval of projections misses the radius on one side.
  always_comb begin
    logic signed [KW-1:0] r;
    logic gt, lt;
    for (int k = 0; k < 3; k++) begin
      for (int a = 0; a < 3; a++) begin
        r  = $signed({{(KW-RW){1'b0}}, rad_q[k][a]});
        gt = 1'b1;
        lt = 1'b1;
        for (int n = 0; n < 3; n++) begin
          gt &= (KW'(p_q[k][a][n]) > r);
          lt &= (KW'(p_q[k][a][n]) < -r);
        end
        axis_sep[k*3+a] = gt | lt;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    edge5_q        <= |axis_sep;
    box5_q         <= box4_q;
    edge6_q        <= edge5_q;
    box6_q         <= box5_q;
    sep_q.edge_sep <= edge6_q;
    sep_q.box_sep  <= box6_q;
  end

  assign sep_o = sep_q;

endmodule

[design/tbo_plane.sv]
// Triangle-plane test: normal from edges e0 and e1, then split products and sums.
// Depends on tbo_pkg.
module tbo_plane (
  input  logic             clk_i,
  input  tbo_pkg::vcoord_t v0_i [3],
  input  tbo_pkg::ecoord_t e0_i [3],
  input  tbo_pkg::ecoord_t e1_i [3],
  input  tbo_pkg::half_t   half_i [3],
  output logic             plane_sep_o
);
  import tbo_pkg::*;

  logic signed [2*EW-1:0]          ma_q [3];
  logic signed [2*EW-1:0]          mb_q [3];
  vcoord_t                         v0_3_q [3];
  half_t                           h3_q [3];
  logic signed [NW-1:0]            nrm_q [3];
  vcoord_t                         v0_4_q [3];
  half_t                           h4_q [3];
  logic signed [NLO+1+CNW-1:0]     nlo_q [3];
  logic signed [NHI+CNW-1:0]       nhi_q [3];
  logic signed [NLO+1+CNW-1:0]     flo_q [3];
  logic signed [NHI+CNW-1:0]       fhi_q [3];
  logic signed [TW-1:0]            tn_q [3];
  logic signed [TW-1:0]            tf_q [3];
  logic                            sep_q;
  logic signed [CNW-1:0]           near_c [3];
  logic signed [CNW-1:0]           far_c [3];
  logic signed [SW-1:0]            dmin, dmax;

  always_ff @(posedge clk_i) begin
    ma_q[0] <= (2*EW)'(e0_i[1]) * (2*EW)'(e1_i[2]);
    mb_q[0] <= (2*EW)'(e0_i[2]) * (2*EW)'(e1_i[1]);
    ma_q[1] <= (2*EW)'(e0_i[2]) * (2*EW)'(e1_i[0]);
    mb_q[1] <= (2*EW)'(e0_i[0]) * (2*EW)'(e1_i[2]);
    ma_q[2] <= (2*EW)'(e0_i[0]) * (2*EW)'(e1_i[1]);
    mb_q[2] <= (2*EW)'(e0_i[1]) * (2*EW)'(e1_i[0]);
    v0_3_q  <= v0_i;
    h3_q    <= half_i;
  end

  always_ff @(posedge clk_i) begin
    for (int q = 0; q < 3; q++) begin
      nrm_q[q] <= NW'(ma_q[q]) - NW'(mb_q[q]);
    end
    v0_4_q <= v0_3_q;
    h4_q   <= h3_q;
  end

  // Pick the box corners nearest to and farthest from the plane.
  always_comb begin
    logic signed [CNW-1:0] hs, vs;
    logic pos;
    for (int q = 0; q < 3; q++) begin
      hs  = CNW'($signed({1'b0, h4_q[q]}));
      vs  = CNW'(v0_4_q[q]);
      pos = !nrm_q[q][NW-1] && (nrm_q[q] != '0);
      near_c[q] = pos ? (-hs - vs) : (hs - vs);
      far_c[q]  = pos ? (hs - vs) : (-hs - vs);
    end
  end

  // The normal is split in two halves to keep each multiplier narrow.
  always_ff @(posedge clk_i) begin
    for (int q = 0; q < 3; q++) begin
      nlo_q[q] <= (NLO+1+CNW)'($signed({1'b0, nrm_q[q][NLO-1:0]})) *
                  (NLO+1+CNW)'(near_c[q]);
      nhi_q[q] <= (NHI+CNW)'($signed(nrm_q[q][NW-1:NLO])) * (NHI+CNW)'(near_c[q]);
      flo_q[q] <= (NLO+1+CNW)'($signed({1'b0, nrm_q[q][NLO-1:0]})) *
                  (NLO+1+CNW)'(far_c[q]);
      fhi_q[q] <= (NHI+CNW)'($signed(nrm_q[q][NW-1:NLO])) * (NHI+CNW)'(far_c[q]);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int q = 0; q < 3; q++) begin
      tn_q[q] <= (TW'(nhi_q[q]) <<< NLO) + TW'(nlo_q[q]);
      tf_q[q] <= (TW'(fhi_q[q]) <<< NLO) + TW'(flo_q[q]);
    end
  end

  always_comb begin
    dmin = SW'(tn_q[0]) + SW'(tn_q[1]) + SW'(tn_q[2]);
    dmax = SW'(tf_q[0]) + SW'(tf_q[1]) + SW'(tf_q[2]);
  end

  always_ff @(posedge clk_i) begin
    sep_q <= (!dmin[SW-1] && (dmin != '0)) || dmax[SW-1];
  end

  assign plane_sep_o = sep_q;

endmodule

[design/triangle_box_overlap.sv]
// Top level of the triangle/box overlap test: config registers, valid chain.
// Depends on tbo_pkg, tbo_diff, tbo_edge, tbo_plane and the macro header.
//
//  channel | signals                                   | handshake
//  input   | start, vert*_i, center*_i                 | start high, busy low
//  config  | cfg_we_i, cfg_idx_i, cfg_wdata_i          | write enable high
//  result  | out_valid_o, overlap_o                    | one-cycle strobe
//
// The strobe for an accepted word passes through the seven register stages
// (differences, edges, products, sums, split products, partial combine, final
// sums) alongside its data. A new word may enter every cycle.
// Reset clears the valid chain and sets each half size to 128.
// Results cannot be stalled, so busy stays low.
module triangle_box_overlap (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  logic                  cfg_we_i,
  input  logic [1:0]            cfg_idx_i,
  input  logic [tbo_pkg::HW-1:0] cfg_wdata_i,
  input  tbo_pkg::coord_t       vert0_x_i,
  input  tbo_pkg::coord_t       vert0_y_i,
  input  tbo_pkg::coord_t       vert0_z_i,
  input  tbo_pkg::coord_t       vert1_x_i,
  input  tbo_pkg::coord_t       vert1_y_i,
  input  tbo_pkg::coord_t       vert1_z_i,
  input  tbo_pkg::coord_t       vert2_x_i,
  input  tbo_pkg::coord_t       vert2_y_i,
  input  tbo_pkg::coord_t       vert2_z_i,
  input  tbo_pkg::coord_t       center_x_i,
  input  tbo_pkg::coord_t       center_y_i,
  input  tbo_pkg::coord_t       center_z_i,
  output logic                  out_valid_o,
  output logic                  overlap_o
);
  import tbo_pkg::*;
`include "triangle_box_overlap_macros.svh"

  half_t              half_q [3];
  logic [LATENCY-1:0] vld_q;
  coord_t             vert [3][3];
  coord_t             center [3];
  vcoord_t            v [3][3];
  ecoord_t            e [3][3];
  half_t              half_p [3];
  sep_t               sep;
  logic               plane_sep;
  logic               accept;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_q[0] <= HW'(128);
      half_q[1] <= HW'(128);
      half_q[2] <= HW'(128);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_HALF_X: half_q[0] <= cfg_wdata_i;
        CFG_HALF_Y: half_q[1] <= cfg_wdata_i;
        CFG_HALF_Z: half_q[2] <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[LATENCY-2:0], accept};
    end
  end

  assign vert[0][0] = vert0_x_i;
  assign vert[0][1] = vert0_y_i;
  assign vert[0][2] = vert0_z_i;
  assign vert[1][0] = vert1_x_i;
  assign vert[1][1] = vert1_y_i;
  assign vert[1][2] = vert1_z_i;
  assign vert[2][0] = vert2_x_i;
  assign vert[2][1] = vert2_y_i;
  assign vert[2][2] = vert2_z_i;
  assign center[0]  = center_x_i;
  assign center[1]  = center_y_i;
  assign center[2]  = center_z_i;

  tbo_diff u_diff (
    .clk_i    (clk_i),
    .vert_i   (vert),
    .center_i (center),
    .half_i   (half_q),
    .v_o      (v),
    .e_o      (e),
    .half_o   (half_p)
  );

  tbo_edge u_edge (
    .clk_i  (clk_i),
    .v_i    (v),
    .e_i    (e),
    .half_i (half_p),
    .sep_o  (sep)
  );

  tbo_plane u_plane (
    .clk_i       (clk_i),
    .v0_i        (v[0]),
    .e0_i        (e[0]),
    .e1_i        (e[1]),
    .half_i      (half_p),
    .plane_sep_o (plane_sep)
  );

  assign out_valid_o = vld_q[LATENCY-1];
  assign overlap_o   = !sep.edge_sep && !sep.box_sep && !plane_sep;

  // A result strobe always traces back to an accepted word.
  `TBO_ASSERT_SAME(a_strobe_has_word, out_valid_o, $past(accept, LATENCY))
  // A word accepted now moves one stage down the valid chain.
  `TBO_ASSERT_NEXT(a_chain_moves, accept, vld_q[0])
  // The next-to-last valid stage drains into the result strobe in the next cycle.
  `TBO_ASSERT_NEXT(a_chain_drains, vld_q[LATENCY-2], out_valid_o)

endmodule

[verif/tb.sv]
// Self-checking testbench for triangle_box_overlap: random and directed words,
// an exact separating-axis predictor and a small scoreboard. Needs tbo_pkg.
`timescale 1ns / 1ps

module tb;
  import tbo_pkg::*;

  typedef logic signed [127:0] wide_t;
  typedef struct packed {
    coord_t [2:0][2:0] vtx;  // [vertex][axis]
    coord_t [2:0]      ctr;
  } tri_word_t;

  localparam logic [1:0] CFG_IDX_UNUSED = 2'd3;
  localparam int IDLE_LIMIT = 5000;

  class overlap_board;
    bit expected_q[$];
    int fails;
    function void note(bit exp);
      expected_q.push_back(exp);
    endfunction
    function void check(bit act);
      bit exp;
      if (expected_q.size() == 0) begin
        $error("overlap: result with nothing expected, actual %0d", act);
        fails++;
        return;
      end
      exp = expected_q.pop_front();
      if (exp != act) begin
        $error("overlap: expected %0d actual %0d", exp, act);
        fails++;
      end
    endfunction
  endclass

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  logic      cfg_we_i = 1'b0;
  logic [1:0] cfg_idx_i = CFG_HALF_X;
  half_t     cfg_wdata_i = '0;
  tri_word_t word_d = '0;
  logic      out_valid_o;
  logic      overlap_o;

  overlap_board board = new();
  half_t half_sh[3] = '{23'd128, 23'd128, 23'd128};
  int idle_cycles;
  int burst_left;

  triangle_box_overlap u_top (
    .clk_i, .rst_ni, .start, .busy, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .vert0_x_i(word_d.vtx[0][0]), .vert0_y_i(word_d.vtx[0][1]),
    .vert0_z_i(word_d.vtx[0][2]), .vert1_x_i(word_d.vtx[1][0]),
    .vert1_y_i(word_d.vtx[1][1]), .vert1_z_i(word_d.vtx[1][2]),
    .vert2_x_i(word_d.vtx[2][0]), .vert2_y_i(word_d.vtx[2][1]),
    .vert2_z_i(word_d.vtx[2][2]), .center_x_i(word_d.ctr[0]),
    .center_y_i(word_d.ctr[1]), .center_z_i(word_d.ctr[2]),
    .out_valid_o, .overlap_o
  );

  initial forever #5 clk_i = ~clk_i;

  function automatic wide_t mulw(longint a, longint b);
    wide_t wa, wb;
    wa = wide_t'(a);
    wb = wide_t'(b);
    return wa * wb;
  endfunction

  function automatic longint absl(longint a);
    return (a < 0) ? -a : a;
  endfunction

  // Exact separating-axis test with the box centered at the origin.
  function automatic bit tri_box_overlap(tri_word_t w);
    longint v[3][3], e[3][3], h[3], nc, fc, lo, hi;
    wide_t p, plo, phi, rad, nrm[3], dmin, dmax;
    int ax_i[3], ax_j[3];
    ax_i = '{1, 0, 0};
    ax_j = '{2, 2, 1};
    for (int k = 0; k < 3; k++) begin
      h[k] = longint'(half_sh[k]);
      for (int n = 0; n < 3; n++)
        v[n][k] = longint'(coord_t'(w.vtx[n][k])) - longint'(coord_t'(w.ctr[k]));
    end
    for (int k = 0; k < 3; k++) begin
      e[0][k] = v[1][k] - v[0][k];
      e[1][k] = v[2][k] - v[1][k];
      e[2][k] = v[0][k] - v[2][k];
    end
    for (int k = 0; k < 3; k++) begin
      for (int a = 0; a < 3; a++) begin
        for (int n = 0; n < 3; n++) begin
          p = mulw(e[k][ax_j[a]], v[n][ax_i[a]]) - mulw(e[k][ax_i[a]], v[n][ax_j[a]]);
          if (n == 0 || p < plo) plo = p;
          if (n == 0 || p > phi) phi = p;
        end
        rad = mulw(absl(e[k][ax_j[a]]), h[ax_i[a]])
            + mulw(absl(e[k][ax_i[a]]), h[ax_j[a]]);
        if (plo > rad || phi < -rad) return 1'b0;
      end
    end
    for (int k = 0; k < 3; k++) begin
      lo = v[0][k];
      hi = v[0][k];
      for (int q = 1; q < 3; q++) begin
        if (v[q][k] < lo) lo = v[q][k];
        if (v[q][k] > hi) hi = v[q][k];
      end
      if (lo > h[k] || hi < -h[k]) return 1'b0;
    end
    nrm[0] = mulw(e[0][1], e[1][2]) - mulw(e[0][2], e[1][1]);
    nrm[1] = mulw(e[0][2], e[1][0]) - mulw(e[0][0], e[1][2]);
    nrm[2] = mulw(e[0][0], e[1][1]) - mulw(e[0][1], e[1][0]);
    dmin = 0;
    dmax = 0;
    for (int q = 0; q < 3; q++) begin
      if (nrm[q] > 0) begin
        nc = -h[q] - v[0][q];
        fc = h[q] - v[0][q];
      end else begin
        nc = h[q] - v[0][q];
        fc = -h[q] - v[0][q];
      end
      dmin += nrm[q] * wide_t'(nc);
      dmax += nrm[q] * wide_t'(fc);
    end
    if (dmin > 0) return 1'b0;
    return dmax >= 0;
  endfunction

  // Inputs and outputs are read before the edge's nonblocking updates land.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) board.note(tri_box_overlap(word_d));
      if (out_valid_o) board.check(overlap_o);
      if ((start && !busy) || out_valid_o || cfg_we_i) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  task automatic send_word(tri_word_t w);
    int gap;
    start <= 1'b1;
    word_d <= w;
    do @(posedge clk_i); while (busy);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end else begin
      burst_left--;
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (board.expected_q.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 3) @(posedge clk_i);
  endtask

  // The enable drops after each write.
  task automatic write_half(logic [1:0] idx, half_t val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    if (idx != CFG_IDX_UNUSED) half_sh[idx] = val;
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic tri_word_t make_word(longint cx, longint cy, longint cz,
                                          longint a[9]);
    tri_word_t w;
    w.ctr[0] = coord_t'(cx);
    w.ctr[1] = coord_t'(cy);
    w.ctr[2] = coord_t'(cz);
    for (int n = 0; n < 3; n++)
      for (int k = 0; k < 3; k++)
        w.vtx[n][k] = coord_t'(a[n * 3 + k] + ((k == 0) ? cx : (k == 1) ? cy : cz));
    return w;
  endfunction

  // Mostly triangles near the box at a random scale; the rest fully random.
  function automatic tri_word_t random_word();
    tri_word_t w;
    longint a[9];
    int sc;
    if ($urandom_range(0, 4) == 0) begin
      for (int n = 0; n < 3; n++)
        for (int k = 0; k < 3; k++) w.vtx[n][k] = coord_t'($urandom);
      for (int k = 0; k < 3; k++) w.ctr[k] = coord_t'($urandom);
      return w;
    end
    sc = $urandom_range(4, 23);
    for (int i = 0; i < 9; i++)
      a[i] = longint'($urandom_range(0, (1 << sc) - 1)) - (longint'(1) << (sc - 1));
    if ($urandom_range(0, 7) == 0) begin
      // Collinear or coincident vertices give a zero normal.
      for (int k = 0; k < 3; k++) a[6 + k] = 2 * a[3 + k] - a[k];
    end
    return make_word($signed(coord_t'($urandom)), $signed(coord_t'($urandom)),
                     $signed(coord_t'($urandom)), a);
  endfunction

  task automatic random_phase(int count);
    repeat (count) send_word(random_word());
    drain();
  endtask

  initial begin
    tri_word_t w;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed words at reset half sizes of 128.
    send_word('0);
    w = '1;
    send_word(w);
    for (int n = 0; n < 3; n++)
      for (int k = 0; k < 3; k++) w.vtx[n][k] = {1'b0, {(COORD_WIDTH - 1){1'b1}}};
    for (int k = 0; k < 3; k++) w.ctr[k] = {1'b0, {(COORD_WIDTH - 1){1'b1}}};
    send_word(w);
    for (int n = 0; n < 3; n++)
      for (int k = 0; k < 3; k++) w.vtx[n][k] = {1'b1, {(COORD_WIDTH - 1){1'b0}}};
    send_word(w);
    for (int k = 0; k < 3; k++) w.ctr[k] = {1'b1, {(COORD_WIDTH - 1){1'b0}}};
    send_word(w);
    w.vtx[1] = {3{1'b0, {(COORD_WIDTH - 1){1'b1}}}};
    send_word(w);
    // Vertex touching the x face, then one step beyond it.
    send_word(make_word(1000, -20, 5, '{128, 0, 0, 300, 0, 0, 300, 10, 0}));
    send_word(make_word(1000, -20, 5, '{129, 0, 0, 300, 0, 0, 300, 10, 0}));
    // Large triangle in a plane touching the top face, then just above it.
    send_word(make_word(0, 0, 0, '{-5000, -5000, 128, 5000, -5000, 128,
                                   0, 5000, 128}));
    send_word(make_word(0, 0, 0, '{-5000, -5000, 129, 5000, -5000, 129,
                                   0, 5000, 129}));
    // Tilted plane passing a corner exactly and just missing it.
    send_word(make_word(7, 7, 7, '{384, 0, 0, 0, 384, 0, 0, 0, 384}));
    send_word(make_word(7, 7, 7, '{385, 0, 0, 0, 385, 0, 0, 0, 385}));
    // Edge-axis separation: a diagonal sliver beside a box edge.
    send_word(make_word(0, 0, 0, '{200, 100, -900, 100, 200, -900, 100, 200, 900}));
    send_word(make_word(0, 0, 0, '{257, 0, -900, 0, 257, -900, 0, 257, 900}));
    // Degenerate segment through the box and beside it.
    send_word(make_word(-3, 9, 0, '{-900, 0, 0, 900, 0, 0, 0, 0, 0}));
    send_word(make_word(-3, 9, 0, '{-900, 300, 0, 900, 300, 0, 0, 300, 0}));
    drain();
    random_phase(100);

    write_half(CFG_HALF_X, '0);
    write_half(CFG_HALF_Y, '0);
    write_half(CFG_HALF_Z, '0);
    send_word('0);
    send_word(make_word(0, 0, 0, '{0, 0, 0, 10, 0, 0, 0, 10, 0}));
    send_word(make_word(0, 0, 0, '{1, 1, 0, 10, 0, 0, 0, 10, 0}));
    random_phase(90);

    write_half(CFG_HALF_X, {HW{1'b1}});
    write_half(CFG_HALF_Y, {HW{1'b1}});
    write_half(CFG_HALF_Z, {HW{1'b1}});
    random_phase(100);

    // An out-of-range index must leave every half size alone.
    write_half(CFG_IDX_UNUSED, 23'd5);
    random_phase(60);

    for (int ph = 0; ph < 4; ph++) begin
      write_half(CFG_HALF_X, half_t'($urandom_range(0, 1 << (4 * ph + 6))));
      write_half(CFG_HALF_Y, half_t'($urandom_range(0, 1 << (4 * ph + 6))));
      write_half(CFG_HALF_Z, half_t'($urandom));
      random_phase(90);
    end

    if (board.fails == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
